### design/srsw_pkg.sv
// Package for the selective-repeat sender window.
// Word types, request and status codes, register indexes and sequencer states.
// No dependencies.
package srsw_pkg;

    localparam int MAX_WINDOW_DEF = 16;
    localparam logic [5:0] WINDOW_SIZE_RESET = 6'd16;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;

    localparam logic [1:0] REQ_SEND = 2'd0;
    localparam logic [1:0] REQ_ACK_OK = 2'd1;
    localparam logic [1:0] REQ_ACK_BAD = 2'd2;
    localparam logic [1:0] REQ_TICK = 2'd3;

    typedef enum logic [2:0] {
        STAT_SENT  = 3'd0,
        STAT_FULL  = 3'd1,
        STAT_ACKED = 3'd2,
        STAT_RETX  = 3'd3,
        STAT_NONE  = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] ack_packet;
        logic        is_final;
    } req_word_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] packet_number;
        logic        packet_final;
        logic [31:0] base_now;
        logic        last_result;
    } res_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_DISPATCH,
        ST_ACK_SLOT,
        ST_ACK_ADV,
        ST_ACK_RETX,
        ST_EMIT,
        ST_TICK_RD,
        ST_TICK_EVAL,
        ST_TICK_END
    } state_t;

    typedef enum logic [1:0] {
        MOD_BASE,
        MOD_NEXT,
        MOD_ACK
    } mod_tgt_t;

endpackage

### design/selective_repeat_sender_window_top.sv
// Selective-repeat sender window: sequencer, slot flags, slot memories, remainder unit.
// Depends on srsw_pkg.
//
// Usage: the request channel (req_valid, req_stall, req_word) takes one word per
// request: a send, an intact or corrupt ack, or a time tick. The result channel
// (res_valid, res_stall, res_word) returns one word per send or ack and one word
// per retransmitted slot for a tick (a single "nothing" word if none); the last
// word of each request has last_result set. One request is processed at a time.
// An intact ack advances the base over done slots, at most 2*W of them. An
// in-window ack 2*W or more numbers above the base (after a window shrink) or
// past the 2^32 wrap finds its slot with the bit-serial remainder unit. A tick
// scans all 2*W slots. The result register lets the next request be taken while
// the last word waits; a stalled receiver holds the word and the sequencer waits
// before writing the next one. After a window_size write the slot indexes of
// base and next number are recomputed by the remainder unit before the next
// request is taken. Reset clears all flags, numbers and time and restores
// window_size 16 and timeout_ticks 1000; slot memories are not cleared.
module selective_repeat_sender_window_top #(
    parameter int MAX_WINDOW = srsw_pkg::MAX_WINDOW_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  srsw_pkg::req_word_t            req_word,
    output logic                           res_valid,
    input  logic                           res_stall,
    output srsw_pkg::res_word_t            res_word,
    input  logic                           cfg_write,
    input  logic [srsw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [srsw_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int SLOTS = 2 * MAX_WINDOW;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = SLOT_W + 1;

    srsw_pkg::state_t   state_reg, state_next;
    srsw_pkg::req_word_t item_reg, item_next;
    srsw_pkg::mod_tgt_t mod_tgt_reg, mod_tgt_next;
    srsw_pkg::res_word_t res_word_reg, res_word_next;
    srsw_pkg::status_t  rstat_reg, rstat_next;

    logic [5:0]        win_size_reg, win_size_next;
    logic [15:0]       timeout_reg, timeout_next;
    logic              dirty_reg, dirty_next;
    logic [31:0]       base_reg, base_next;
    logic [31:0]       next_reg, next_next;
    logic [31:0]       time_reg, time_next;
    logic [SLOT_W-1:0] base_slot_reg, base_slot_next;
    logic [SLOT_W-1:0] next_slot_reg, next_slot_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOTS-1:0]  done_reg, done_next;
    logic [SLOTS-1:0]  outst_reg, outst_next;
    logic [CNT_W-1:0]  adv_cnt_reg, adv_cnt_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [31:0]       pend_pn_reg, pend_pn_next;
    logic              pend_fin_reg, pend_fin_next;
    logic [31:0]       rpn_reg, rpn_next;
    logic              rfin_reg, rfin_next;
    logic              res_valid_reg, res_valid_next;
    logic [CNT_W-1:0]  mod_rem_reg, mod_rem_next;
    logic [31:0]       mod_div_reg, mod_div_next;
    logic [4:0]        mod_cnt_reg, mod_cnt_next;

    // slot memories
    logic [31:0]       start_mem [SLOTS];
    logic [31:0]       packet_mem [SLOTS];
    logic              final_mem [SLOTS];
    logic [31:0]       start_rd_reg;
    logic [31:0]       packet_rd_reg;
    logic              final_rd_reg;
    logic [SLOT_W-1:0] mem_rd_addr;
    logic [SLOT_W-1:0] mem_wr_addr;
    logic              we_start;
    logic              we_entry;

    logic [5:0]        win_eff;
    logic [CNT_W-1:0]  nslots;
    logic              out_free;
    logic [31:0]       ack_dist;
    logic [31:0]       flight;
    logic [7:0]        ack_sum;
    logic [7:0]        ack_slot8;
    logic [CNT_W:0]    rem_sh;
    logic [CNT_W-1:0]  rem_new;
    logic [CNT_W-1:0]  slot_inc;
    logic [SLOT_W-1:0] scan_idx;

    always_comb
    begin
        win_eff = win_size_reg;
        if (win_size_reg == 6'd0)
        begin
            win_eff = 6'd1;
        end
        else if (win_size_reg > 6'(MAX_WINDOW))
        begin
            win_eff = 6'(MAX_WINDOW);
        end
    end

    assign nslots = CNT_W'({win_eff, 1'b0});
    assign out_free = !res_valid_reg || !res_stall;
    assign ack_dist = item_reg.ack_packet - base_reg;
    assign flight = next_reg - base_reg;
    assign ack_sum = 8'(base_slot_reg) + ack_dist[7:0];
    assign ack_slot8 = (ack_sum >= 8'(nslots)) ? ack_sum - 8'(nslots) : ack_sum;
    assign rem_sh = {mod_rem_reg, mod_div_reg[31]};
    assign rem_new = (rem_sh >= (CNT_W + 1)'(nslots)) ?
                     CNT_W'(rem_sh - (CNT_W + 1)'(nslots)) : CNT_W'(rem_sh);
    assign scan_idx = scan_reg[SLOT_W-1:0];

    assign req_stall = (state_reg != srsw_pkg::ST_IDLE) || dirty_reg || cfg_write;
    assign res_valid = res_valid_reg;
    assign res_word = res_word_reg;

    always_ff @(posedge clk)
    begin
        if (we_start)
        begin
            start_mem[mem_wr_addr] <= time_reg;
        end
        if (we_entry)
        begin
            packet_mem[mem_wr_addr] <= next_reg;
            final_mem[mem_wr_addr] <= item_reg.is_final;
        end
        start_rd_reg <= start_mem[mem_rd_addr];
        packet_rd_reg <= packet_mem[mem_rd_addr];
        final_rd_reg <= final_mem[mem_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srsw_pkg::ST_IDLE;
            item_reg <= '0;
            mod_tgt_reg <= srsw_pkg::MOD_BASE;
            res_word_reg <= '0;
            rstat_reg <= srsw_pkg::STAT_NONE;
            win_size_reg <= srsw_pkg::WINDOW_SIZE_RESET;
            timeout_reg <= srsw_pkg::TIMEOUT_RESET;
            dirty_reg <= 1'b0;
            base_reg <= '0;
            next_reg <= '0;
            time_reg <= '0;
            base_slot_reg <= '0;
            next_slot_reg <= '0;
            slot_reg <= '0;
            done_reg <= '0;
            outst_reg <= '0;
            adv_cnt_reg <= '0;
            scan_reg <= '0;
            pend_valid_reg <= 1'b0;
            pend_pn_reg <= '0;
            pend_fin_reg <= 1'b0;
            rpn_reg <= '0;
            rfin_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            mod_rem_reg <= '0;
            mod_div_reg <= '0;
            mod_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            item_reg <= item_next;
            mod_tgt_reg <= mod_tgt_next;
            res_word_reg <= res_word_next;
            rstat_reg <= rstat_next;
            win_size_reg <= win_size_next;
            timeout_reg <= timeout_next;
            dirty_reg <= dirty_next;
            base_reg <= base_next;
            next_reg <= next_next;
            time_reg <= time_next;
            base_slot_reg <= base_slot_next;
            next_slot_reg <= next_slot_next;
            slot_reg <= slot_next;
            done_reg <= done_next;
            outst_reg <= outst_next;
            adv_cnt_reg <= adv_cnt_next;
            scan_reg <= scan_next;
            pend_valid_reg <= pend_valid_next;
            pend_pn_reg <= pend_pn_next;
            pend_fin_reg <= pend_fin_next;
            rpn_reg <= rpn_next;
            rfin_reg <= rfin_next;
            res_valid_reg <= res_valid_next;
            mod_rem_reg <= mod_rem_next;
            mod_div_reg <= mod_div_next;
            mod_cnt_reg <= mod_cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        item_next = item_reg;
        mod_tgt_next = mod_tgt_reg;
        res_word_next = res_word_reg;
        rstat_next = rstat_reg;
        win_size_next = win_size_reg;
        timeout_next = timeout_reg;
        dirty_next = dirty_reg;
        base_next = base_reg;
        next_next = next_reg;
        time_next = time_reg;
        base_slot_next = base_slot_reg;
        next_slot_next = next_slot_reg;
        slot_next = slot_reg;
        done_next = done_reg;
        outst_next = outst_reg;
        adv_cnt_next = adv_cnt_reg;
        scan_next = scan_reg;
        pend_valid_next = pend_valid_reg;
        pend_pn_next = pend_pn_reg;
        pend_fin_next = pend_fin_reg;
        rpn_next = rpn_reg;
        rfin_next = rfin_reg;
        res_valid_next = res_valid_reg && res_stall;
        mod_rem_next = mod_rem_reg;
        mod_div_next = mod_div_reg;
        mod_cnt_next = mod_cnt_reg;
        mem_rd_addr = slot_reg;
        mem_wr_addr = slot_reg;
        we_start = 1'b0;
        we_entry = 1'b0;
        slot_inc = '0;

        case (state_reg)
            srsw_pkg::ST_IDLE:
            begin
                if (dirty_reg)
                begin
                    mod_rem_next = '0;
                    mod_div_next = base_reg;
                    mod_cnt_next = '0;
                    mod_tgt_next = srsw_pkg::MOD_BASE;
                    state_next = srsw_pkg::ST_MOD;
                end
                else if (req_valid && !req_stall)
                begin
                    item_next = req_word;
                    state_next = srsw_pkg::ST_DISPATCH;
                end
            end

            // bit-serial remainder by the slot count
            srsw_pkg::ST_MOD:
            begin
                mod_rem_next = rem_new;
                mod_div_next = {mod_div_reg[30:0], 1'b0};
                mod_cnt_next = mod_cnt_reg + 5'd1;
                if (mod_cnt_reg == 5'd31)
                begin
                    case (mod_tgt_reg)
                        srsw_pkg::MOD_BASE:
                        begin
                            base_slot_next = rem_new[SLOT_W-1:0];
                            mod_rem_next = '0;
                            mod_div_next = next_reg;
                            mod_cnt_next = '0;
                            mod_tgt_next = srsw_pkg::MOD_NEXT;
                        end
                        srsw_pkg::MOD_NEXT:
                        begin
                            next_slot_next = rem_new[SLOT_W-1:0];
                            dirty_next = 1'b0;
                            state_next = srsw_pkg::ST_IDLE;
                        end
                        default:
                        begin
                            slot_next = rem_new[SLOT_W-1:0];
                            state_next = srsw_pkg::ST_ACK_SLOT;
                        end
                    endcase
                end
            end

            srsw_pkg::ST_DISPATCH:
            begin
                case (item_reg.req_type)
                    srsw_pkg::REQ_SEND:
                    begin
                        state_next = srsw_pkg::ST_EMIT;
                        if (flight < 32'(win_eff))
                        begin
                            mem_wr_addr = next_slot_reg;
                            we_start = 1'b1;
                            we_entry = 1'b1;
                            done_next[next_slot_reg] = 1'b0;
                            outst_next[next_slot_reg] = 1'b1;
                            next_next = next_reg + 32'd1;
                            slot_inc = CNT_W'(next_slot_reg) + 1'b1;
                            // number wrap restarts at slot 0
                            next_slot_next = (slot_inc == nslots || next_reg == '1) ?
                                             '0 : slot_inc[SLOT_W-1:0];
                            rstat_next = srsw_pkg::STAT_SENT;
                            rpn_next = next_reg;
                            rfin_next = item_reg.is_final;
                        end
                        else
                        begin
                            rstat_next = srsw_pkg::STAT_FULL;
                            rpn_next = '0;
                            rfin_next = 1'b0;
                        end
                    end
                    srsw_pkg::REQ_ACK_OK, srsw_pkg::REQ_ACK_BAD:
                    begin
                        if (!(ack_dist < flight))
                        begin
                            rstat_next = srsw_pkg::STAT_NONE;
                            rpn_next = '0;
                            rfin_next = 1'b0;
                            state_next = srsw_pkg::ST_EMIT;
                        end
                        else if (ack_dist < 32'(nslots) && item_reg.ack_packet >= base_reg)
                        begin
                            slot_next = ack_slot8[SLOT_W-1:0];
                            state_next = srsw_pkg::ST_ACK_SLOT;
                        end
                        else
                        begin
                            mod_rem_next = '0;
                            mod_div_next = item_reg.ack_packet;
                            mod_cnt_next = '0;
                            mod_tgt_next = srsw_pkg::MOD_ACK;
                            state_next = srsw_pkg::ST_MOD;
                        end
                    end
                    srsw_pkg::REQ_TICK:
                    begin
                        time_next = time_reg + 32'd1;
                        scan_next = '0;
                        pend_valid_next = 1'b0;
                        state_next = srsw_pkg::ST_TICK_RD;
                    end
                    default:
                    begin
                        state_next = srsw_pkg::ST_IDLE;
                    end
                endcase
            end

            srsw_pkg::ST_ACK_SLOT:
            begin
                if (item_reg.req_type == srsw_pkg::REQ_ACK_OK)
                begin
                    done_next[slot_reg] = 1'b1;
                    outst_next[slot_reg] = 1'b0;
                    adv_cnt_next = '0;
                    state_next = srsw_pkg::ST_ACK_ADV;
                end
                else if (!outst_reg[slot_reg] || done_reg[slot_reg])
                begin
                    rstat_next = srsw_pkg::STAT_NONE;
                    rpn_next = '0;
                    rfin_next = 1'b0;
                    state_next = srsw_pkg::ST_EMIT;
                end
                else
                begin
                    we_start = 1'b1;
                    state_next = srsw_pkg::ST_ACK_RETX;
                end
            end

            // walk the base over done slots
            srsw_pkg::ST_ACK_ADV:
            begin
                if (adv_cnt_reg < nslots && base_reg != next_reg && done_reg[base_slot_reg])
                begin
                    base_next = base_reg + 32'd1;
                    slot_inc = CNT_W'(base_slot_reg) + 1'b1;
                    base_slot_next = (slot_inc == nslots || base_reg == '1) ?
                                     '0 : slot_inc[SLOT_W-1:0];
                    adv_cnt_next = adv_cnt_reg + 1'b1;
                end
                else
                begin
                    rstat_next = srsw_pkg::STAT_ACKED;
                    rpn_next = item_reg.ack_packet;
                    rfin_next = final_rd_reg;
                    state_next = srsw_pkg::ST_EMIT;
                end
            end

            srsw_pkg::ST_ACK_RETX:
            begin
                rstat_next = srsw_pkg::STAT_RETX;
                rpn_next = packet_rd_reg;
                rfin_next = final_rd_reg;
                state_next = srsw_pkg::ST_EMIT;
            end

            srsw_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_word_next.status = rstat_reg;
                    res_word_next.packet_number = rpn_reg;
                    res_word_next.packet_final = rfin_reg;
                    res_word_next.base_now = base_reg;
                    res_word_next.last_result = 1'b1;
                    state_next = srsw_pkg::ST_IDLE;
                end
            end

            srsw_pkg::ST_TICK_RD:
            begin
                mem_rd_addr = scan_idx;
                if (scan_reg == nslots)
                begin
                    state_next = srsw_pkg::ST_TICK_END;
                end
                else if (outst_reg[scan_idx] && !done_reg[scan_idx])
                begin
                    state_next = srsw_pkg::ST_TICK_EVAL;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            // one retransmit held back so the last word of the tick can be marked
            srsw_pkg::ST_TICK_EVAL:
            begin
                mem_rd_addr = scan_idx;
                mem_wr_addr = scan_idx;
                if ((time_reg - start_rd_reg) > 32'(timeout_reg))
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            res_valid_next = 1'b1;
                            res_word_next.status = srsw_pkg::STAT_RETX;
                            res_word_next.packet_number = pend_pn_reg;
                            res_word_next.packet_final = pend_fin_reg;
                            res_word_next.base_now = base_reg;
                            res_word_next.last_result = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_pn_next = packet_rd_reg;
                        pend_fin_next = final_rd_reg;
                        we_start = 1'b1;
                        scan_next = scan_reg + 1'b1;
                        state_next = srsw_pkg::ST_TICK_RD;
                    end
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                    state_next = srsw_pkg::ST_TICK_RD;
                end
            end

            srsw_pkg::ST_TICK_END:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_word_next.status = pend_valid_reg ? srsw_pkg::STAT_RETX
                                                          : srsw_pkg::STAT_NONE;
                    res_word_next.packet_number = pend_valid_reg ? pend_pn_reg : '0;
                    res_word_next.packet_final = pend_valid_reg && pend_fin_reg;
                    res_word_next.base_now = base_reg;
                    res_word_next.last_result = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next = srsw_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = srsw_pkg::ST_IDLE;
            end
        endcase

        if (cfg_write)
        begin
            case (cfg_index)
                srsw_pkg::CFG_WINDOW_SIZE:
                begin
                    win_size_next = cfg_data[5:0];
                    dirty_next = 1'b1;
                end
                srsw_pkg::CFG_TIMEOUT:
                begin
                    timeout_next = cfg_data;
                end
                default:
                begin
                    timeout_next = timeout_reg;
                end
            endcase
        end
    end

    a_flight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (next_reg - base_reg) <= 32'(MAX_WINDOW))
        else $error("packets in flight exceed the largest window");

    a_slot_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg & outst_reg) == '0)
        else $error("slot both done and outstanding");

    a_slot_index: assert property (@(posedge clk) disable iff (!rst_n)
        dirty_reg || (CNT_W'(next_slot_reg) < nslots && CNT_W'(base_slot_reg) < nslots))
        else $error("slot index beyond slot count");

    a_pend_scope: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == srsw_pkg::ST_TICK_RD
                            || state_reg == srsw_pkg::ST_TICK_EVAL
                            || state_reg == srsw_pkg::ST_TICK_END))
        else $error("held retransmit outside a tick");

endmodule

### sim/tb_selective_repeat_sender_window_top.sv
// Testbench for selective_repeat_sender_window_top: random and directed requests
// checked word by word against an in-bench window predictor. Depends on srsw_pkg.
`timescale 1ns / 100ps

module tb_selective_repeat_sender_window_top;

    localparam int WIN_MAX = srsw_pkg::MAX_WINDOW_DEF;
    localparam int SLOTS = 2 * WIN_MAX;
    localparam int PHASES = 7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    srsw_pkg::req_word_t req_word = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    srsw_pkg::res_word_t res_word;
    logic cfg_write = 1'b0;
    logic [srsw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [srsw_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // window predictor state
    logic [5:0] cfg_win = srsw_pkg::WINDOW_SIZE_RESET;
    logic [15:0] cfg_timeout = srsw_pkg::TIMEOUT_RESET;
    logic sl_done [SLOTS] = '{default: 1'b0};
    logic sl_out [SLOTS] = '{default: 1'b0};
    logic sl_set [SLOTS] = '{default: 1'b0};
    logic sl_fin [SLOTS] = '{default: 1'b0};
    logic [31:0] sl_stamp [SLOTS] = '{default: '0};
    logic [31:0] sl_pkt [SLOTS] = '{default: '0};
    logic [31:0] win_base = '0;
    logic [31:0] next_num = '0;
    logic [31:0] tick_count = '0;

    srsw_pkg::req_word_t pending_reqs[$];
    srsw_pkg::res_word_t due_results[$];

    logic req_fire = 1'b0;
    bit idle_on = 1'b1;
    int unsigned gap_pct = 15;
    int unsigned stall_pct = 15;
    int unsigned gap_left = 0;
    int unsigned hold_left = 0;
    int unsigned mismatches = 0;

    int unsigned phase_win [PHASES] = '{0, 63, 17, 1, 4, 16, 3};
    int unsigned phase_tmo [PHASES] = '{1, 65535, 5, 3, 2, 7, 1};

    selective_repeat_sender_window_top #(
        .MAX_WINDOW(WIN_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_word(req_word),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_word(res_word),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int unsigned eff_win();
        if (cfg_win == 0)
            return 1;
        if (cfg_win > WIN_MAX)
            return WIN_MAX;
        return cfg_win;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // computes the result words of one request and queues them
    task automatic advance_window(input srsw_pkg::req_word_t rq);
        srsw_pkg::res_word_t r;
        srsw_pkg::res_word_t burst[$];
        int unsigned w;
        int unsigned nsl;
        int unsigned s;
        int unsigned i;
        logic [31:0] span;
        logic [31:0] off;
        w = eff_win();
        nsl = 2 * w;
        r = '0;
        r.status = srsw_pkg::STAT_NONE;
        r.last_result = 1'b1;
        span = next_num - win_base;
        case (rq.req_type)
            srsw_pkg::REQ_SEND:
            begin
                if (span < w)
                begin
                    s = next_num % nsl;
                    sl_done[s] = 1'b0;
                    sl_out[s] = 1'b1;
                    sl_set[s] = 1'b1;
                    sl_stamp[s] = tick_count;
                    sl_pkt[s] = next_num;
                    sl_fin[s] = rq.is_final;
                    r.status = srsw_pkg::STAT_SENT;
                    r.packet_number = next_num;
                    r.packet_final = rq.is_final;
                    next_num++;
                end
                else
                    r.status = srsw_pkg::STAT_FULL;
            end
            srsw_pkg::REQ_ACK_OK, srsw_pkg::REQ_ACK_BAD:
            begin
                off = rq.ack_packet - win_base;
                s = rq.ack_packet % nsl;
                if (off < span)
                begin
                    if (rq.req_type == srsw_pkg::REQ_ACK_OK)
                    begin
                        sl_done[s] = 1'b1;
                        sl_out[s] = 1'b0;
                        for (i = 0; i < nsl && win_base != next_num; i++)
                        begin
                            if (!sl_done[win_base % nsl])
                                break;
                            win_base++;
                        end
                        r.status = srsw_pkg::STAT_ACKED;
                        r.packet_number = rq.ack_packet;
                        r.packet_final = sl_fin[s];
                    end
                    else if (sl_out[s] && !sl_done[s])
                    begin
                        sl_stamp[s] = tick_count;
                        r.status = srsw_pkg::STAT_RETX;
                        r.packet_number = sl_pkt[s];
                        r.packet_final = sl_fin[s];
                    end
                end
            end
            default:
            begin
                tick_count++;
                for (i = 0; i < nsl; i++)
                begin
                    if (sl_out[i] && !sl_done[i] && tick_count - sl_stamp[i] > cfg_timeout)
                    begin
                        sl_stamp[i] = tick_count;
                        r.status = srsw_pkg::STAT_RETX;
                        r.packet_number = sl_pkt[i];
                        r.packet_final = sl_fin[i];
                        r.last_result = 1'b0;
                        burst = {burst, r};
                    end
                end
            end
        endcase
        if (burst.size() == 0)
            burst = {burst, r};
        burst[burst.size() - 1].last_result = 1'b1;
        foreach (burst[k])
        begin
            burst[k].base_now = win_base;
            due_results = {due_results, burst[k]};
        end
    endtask

    task automatic queue_req(input logic [1:0] kind, input logic [31:0] num, input logic fin);
        srsw_pkg::req_word_t rq;
        rq.req_type = kind;
        rq.ack_packet = num;
        rq.is_final = fin;
        pending_reqs = {pending_reqs, rq};
        advance_window(rq);
    endtask

    // mostly sends, in-window acks and ticks; some out-of-window acks as noise
    function automatic srsw_pkg::req_word_t pick_req();
        srsw_pkg::req_word_t rq;
        int unsigned roll;
        int unsigned nsl;
        logic [31:0] span;
        logic [31:0] n;
        nsl = 2 * eff_win();
        span = next_num - win_base;
        roll = $urandom_range(0, 99);
        rq.req_type = srsw_pkg::REQ_SEND;
        rq.ack_packet = $urandom();
        rq.is_final = 1'($urandom_range(0, 1));
        if (roll >= 35 && roll < 70 && span != 0)
        begin
            n = win_base;
            if ($urandom_range(0, 1) == 1)
                n = win_base + $urandom_range(0, span - 1);
            rq.ack_packet = n;
            // an intact ack must not read a slot that was never filled
            rq.req_type = ($urandom_range(0, 3) == 0 || !sl_set[n % nsl]) ?
                          srsw_pkg::REQ_ACK_BAD : srsw_pkg::REQ_ACK_OK;
        end
        else if (roll >= 70 && roll < 90)
            rq.req_type = srsw_pkg::REQ_TICK;
        else if (roll >= 90)
        begin
            rq.req_type = ($urandom_range(0, 1) == 1) ? srsw_pkg::REQ_ACK_OK
                                                      : srsw_pkg::REQ_ACK_BAD;
            if (rq.ack_packet - win_base < span)
                rq.ack_packet = next_num + $urandom_range(0, 7);
        end
        return rq;
    endfunction

    task automatic write_reg(input logic [srsw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [srsw_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == srsw_pkg::CFG_WINDOW_SIZE)
            cfg_win = val[5:0];
        else
            cfg_timeout = val;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic await_idle();
        while (pending_reqs.size() != 0 || req_valid || due_results.size() != 0)
            @(negedge clk);
    endtask

    // request driver
    always @(negedge clk)
    begin
        logic holding;
        if (rst_n)
        begin
            holding = req_valid && !req_fire;
            if (req_fire)
                void'(pending_reqs.pop_front());
            if ($urandom_range(0, 63) == 0)
                gap_pct = $urandom_range(0, 2) * 15;
            if (!holding && gap_left == 0 && idle_on && $urandom_range(0, 99) < gap_pct)
                gap_left = $urandom_range(1, 17);
            if (!holding)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    req_valid <= 1'b1;
                    req_word <= pending_reqs[0];
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            stall_pct = $urandom_range(0, 2) * 15;
        if (hold_left == 0 && idle_on && $urandom_range(0, 99) < stall_pct)
            hold_left = $urandom_range(1, 17);
        if (hold_left > 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else
            res_stall <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        srsw_pkg::res_word_t want;
        req_fire = rst_n && req_valid && !req_stall;
        if (rst_n && res_valid && !res_stall)
        begin
            if (due_results.size() == 0)
                report_mismatch($sformatf("unexpected result word %h", res_word));
            else
            begin
                want = due_results.pop_front();
                if (res_word.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              res_word.status, want.status));
                if (res_word.packet_number !== want.packet_number)
                    report_mismatch($sformatf("packet_number %0d, want %0d",
                                              res_word.packet_number, want.packet_number));
                if (res_word.packet_final !== want.packet_final)
                    report_mismatch($sformatf("packet_final %b, want %b",
                                              res_word.packet_final, want.packet_final));
                if (res_word.base_now !== want.base_now)
                    report_mismatch($sformatf("base_now %0d, want %0d",
                                              res_word.base_now, want.base_now));
                if (res_word.last_result !== want.last_result)
                    report_mismatch($sformatf("last_result %b, want %b",
                                              res_word.last_result, want.last_result));
            end
        end
    end

    initial
    begin
        srsw_pkg::req_word_t rq;
        logic [31:0] b;
        logic [srsw_pkg::CFG_DATA_W-1:0] wval;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset register values, then empty the window
        repeat (30)
        begin
            rq = pick_req();
            queue_req(rq.req_type, rq.ack_packet, rq.is_final);
        end
        while (win_base != next_num)
            queue_req(srsw_pkg::REQ_ACK_OK, win_base, 1'b0);
        await_idle();

        write_reg(srsw_pkg::CFG_WINDOW_SIZE, 16'd2);
        write_reg(srsw_pkg::CFG_TIMEOUT, 16'd2);
        b = next_num;
        queue_req(srsw_pkg::REQ_SEND, 32'h0, 1'b0);
        queue_req(srsw_pkg::REQ_SEND, 32'h0, 1'b1);
        queue_req(srsw_pkg::REQ_SEND, 32'h0, 1'b0);           // window full
        queue_req(srsw_pkg::REQ_ACK_BAD, b + 1, 1'b0);        // retransmit on corrupt ack
        queue_req(srsw_pkg::REQ_ACK_OK, b + 1, 1'b0);         // out of order, base holds
        queue_req(srsw_pkg::REQ_ACK_OK, b + 1, 1'b1);         // duplicate
        queue_req(srsw_pkg::REQ_ACK_BAD, b + 1, 1'b0);        // already done
        queue_req(srsw_pkg::REQ_ACK_OK, b + 2, 1'b0);         // above window
        queue_req(srsw_pkg::REQ_ACK_BAD, 32'hFFFF_FFFF, 1'b1);
        queue_req(srsw_pkg::REQ_ACK_OK, b - 1, 1'b0);         // below window
        repeat (4)
            queue_req(srsw_pkg::REQ_TICK, 32'h0, 1'b0);       // timeout on the third
        queue_req(srsw_pkg::REQ_ACK_OK, b, 1'b0);             // base jumps over both
        queue_req(srsw_pkg::REQ_TICK, 32'hFFFF_FFFF, 1'b1);
        queue_req(srsw_pkg::REQ_SEND, 32'hFFFF_FFFF, 1'b1);
        queue_req(srsw_pkg::REQ_SEND, 32'h0, 1'b0);
        queue_req(srsw_pkg::REQ_SEND, 32'h5A5A_A5A5, 1'b1);

        for (int p = 0; p < PHASES; p++)
        begin
            await_idle();
            if (p == PHASES - 1)
                idle_on = 1'b0;
            wval = 16'($urandom());
            wval[5:0] = 6'(phase_win[p]);
            write_reg(srsw_pkg::CFG_WINDOW_SIZE, wval);
            write_reg(srsw_pkg::CFG_TIMEOUT, 16'(phase_tmo[p]));
            repeat (45)
            begin
                rq = pick_req();
                queue_req(rq.req_type, rq.ack_packet, rq.is_final);
            end
        end

        await_idle();
        repeat (80) @(negedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
